// ===== rtl/dq_pkg.sv =====
// Shared types, codes and constants for the double-ended queue.
package dq_pkg;

  localparam int DEPTH    = 16;
  localparam int LIST_CAP = 16;

  localparam logic [2:0] CMD_LIST       = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_LIST_START,
    OP_LIST_READ
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [3:0] cap_m1;
  } dp_status_t;

endpackage

// ===== rtl/dq_datapath.sv =====
// Datapath: ring store, front pointer, entry count and list read pointer.
module dq_datapath #(
  parameter int DEPTH = dq_pkg::DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dq_pkg::dp_cmd_t    cmd_i,
  input  logic signed [31:0] value_i,
  output dq_pkg::dp_status_t status_o,
  output logic signed [31:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  logic [31:0]      mem [DEPTH];
  logic [PTR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [31:0]      rd_data_q;
  logic             list_q;

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] front_inc, front_dec, rd_ptr_inc, back_slot;
  logic [SUM_W-1:0] back_sum;
  logic [CMP_W-1:0] count_ext, cap;

  always_comb begin
    front_inc  = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + PTR_W'(1);
    front_dec  = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - PTR_W'(1);
    rd_ptr_inc = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    back_sum   = SUM_W'(front_q) + SUM_W'(count_q);
    if (back_sum >= SUM_W'(DEPTH)) begin
      back_slot = PTR_W'(back_sum - SUM_W'(DEPTH));
    end else begin
      back_slot = PTR_W'(back_sum);
    end
    count_ext = CMP_W'(count_q);
    cap = (count_ext >= CMP_W'(dq_pkg::LIST_CAP)) ? CMP_W'(dq_pkg::LIST_CAP) : count_ext;
    status_o.empty  = (count_q == '0);
    status_o.full   = (count_q >= CNT_W'(DEPTH));
    status_o.cap_m1 = 4'(cap - CMP_W'(1));
  end

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    wr_en    = 1'b0;
    wr_addr  = back_slot;
    case (cmd_i.op)
      dq_pkg::OP_PUSH_FRONT: begin
        front_d = front_dec;
        count_d = count_q + CNT_W'(1);
        wr_en   = 1'b1;
        wr_addr = front_dec;
      end
      dq_pkg::OP_PUSH_BACK: begin
        count_d = count_q + CNT_W'(1);
        wr_en   = 1'b1;
      end
      dq_pkg::OP_POP_FRONT: begin
        front_d = front_inc;
        count_d = count_q - CNT_W'(1);
      end
      dq_pkg::OP_POP_BACK: begin
        count_d = count_q - CNT_W'(1);
      end
      dq_pkg::OP_LIST_START: begin
        rd_ptr_d = front_q;
      end
      dq_pkg::OP_LIST_READ: begin
        rd_ptr_d = rd_ptr_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    list_q   <= (cmd_i.op == dq_pkg::OP_LIST_READ);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dq_pkg::OP_LIST_READ) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  assign data_o = list_q ? signed'(rd_data_q) : '0;

endmodule

// ===== rtl/dq_ctrl.sv =====
// Controller: command decode, list sequencer and result registers.
module dq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [2:0]         cmd_i,
  output logic               busy,
  input  dq_pkg::dp_status_t dp_status_i,
  output dq_pkg::dp_cmd_t    dp_cmd_o,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [3:0]         position_o,
  output logic               last_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic       state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic [3:0] n_m1_q, n_m1_d;
  logic       valid_q, valid_d;
  logic [1:0] status_q, status_d;
  logic [3:0] pos_q, pos_d;
  logic       last_q, last_d;

  assign busy = (state_q == ST_LIST);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    n_m1_d      = n_m1_q;
    valid_d     = 1'b0;
    status_d    = dq_pkg::STATUS_OK;
    pos_d       = '0;
    last_d      = 1'b1;
    dp_cmd_o.op = dq_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i)
            dq_pkg::CMD_LIST: begin
              if (dp_status_i.empty) begin
                valid_d  = 1'b1;
                status_d = dq_pkg::STATUS_EMPTY;
              end else begin
                dp_cmd_o.op = dq_pkg::OP_LIST_START;
                state_d     = ST_LIST;
                idx_d       = '0;
                n_m1_d      = dp_status_i.cap_m1;
              end
            end
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
              valid_d = 1'b1;
              if (dp_status_i.full) begin
                status_d = dq_pkg::STATUS_FULL;
              end else if (cmd_i == dq_pkg::CMD_PUSH_FRONT) begin
                dp_cmd_o.op = dq_pkg::OP_PUSH_FRONT;
              end else begin
                dp_cmd_o.op = dq_pkg::OP_PUSH_BACK;
              end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
              valid_d = 1'b1;
              if (dp_status_i.empty) begin
                status_d = dq_pkg::STATUS_EMPTY;
              end else if (cmd_i == dq_pkg::CMD_POP_FRONT) begin
                dp_cmd_o.op = dq_pkg::OP_POP_FRONT;
              end else begin
                dp_cmd_o.op = dq_pkg::OP_POP_BACK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        dp_cmd_o.op = dq_pkg::OP_LIST_READ;
        valid_d     = 1'b1;
        pos_d       = idx_q;
        last_d      = (idx_q == n_m1_q);
        idx_d       = idx_q + 4'd1;
        if (idx_q == n_m1_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    n_m1_q   <= n_m1_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    last_q   <= last_d;
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign position_o     = pos_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: controller plus ring-store datapath.
// Push and pop: busy stays low, one result beat in the cycle after start.
// List: busy while up to min(count,16) entries are read, one beat per cycle, the first
// beat after the start decode and the first read; the next command is taken in the cycle after the final read.
// Rate is set by the single read port of the ring store; results cannot be stalled.
// Reset clears front pointer, count and controller; store contents stay undefined.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] value_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [3:0]         position_o,
  output logic signed [31:0] data_o,
  output logic               last_o
);

  dq_pkg::dp_cmd_t    dp_cmd;
  dq_pkg::dp_status_t dp_status;

  dq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .busy           (busy),
    .dp_status_i    (dp_status),
    .dp_cmd_o       (dp_cmd),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .position_o     (position_o),
    .last_o         (last_o)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .value_i  (value_i),
    .status_o (dp_status),
    .data_o   (data_o)
  );

endmodule

// ===== bench/tb_double_ended_queue.sv =====
// Self-checking testbench for double_ended_queue: directed table, then random commands.
`timescale 1ns / 1ps

module tb_double_ended_queue;

  localparam int RANDOM_ITEMS   = 403;
  localparam int QUIET_TAIL     = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_MAX     = 10;
  localparam int HEAD_W         = $clog2(dq_pkg::DEPTH);
  localparam int FILL_W         = $clog2(dq_pkg::DEPTH + 1);

  typedef struct {
    logic [1:0]         status;
    logic [3:0]         position;
    logic signed [31:0] data;
    logic               last;
  } beat_t;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    int                 reps;
    bit                 typed;
    logic [1:0]         t_status;
    logic signed [31:0] t_data;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni  = 1'b0;
  logic               start   = 1'b0;
  logic               busy;
  logic [2:0]         cmd_i   = dq_pkg::CMD_LIST;
  logic signed [31:0] value_i = '0;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic [3:0]         position_o;
  logic signed [31:0] data_o;
  logic               last_o;

  beat_t              expected_beats[$];
  stim_row_t          stim_rows[$];
  beat_t              want_beat;
  int                 errors       = 0;
  int                 quiet_cycles = 0;

  // predictor state
  logic signed [31:0] ring_q[dq_pkg::DEPTH];
  logic [HEAD_W-1:0]  head_q = '0;
  logic [FILL_W-1:0]  fill_q = '0;

  double_ended_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .position_o    (position_o),
    .data_o        (data_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void predict_cmd(input logic [2:0] c, input logic signed [31:0] v);
    int    n;
    beat_t b;
    b.status   = dq_pkg::STATUS_OK;
    b.position = '0;
    b.data     = '0;
    b.last     = 1'b1;
    case (c)
      dq_pkg::CMD_LIST: begin
        if (fill_q == 0) begin
          b.status = dq_pkg::STATUS_EMPTY;
          expected_beats.push_back(b);
        end else begin
          n = (fill_q < dq_pkg::LIST_CAP) ? int'(fill_q) : dq_pkg::LIST_CAP;
          for (int i = 0; i < n; i++) begin
            b.position = i[3:0];
            b.data     = ring_q[(head_q + i) % dq_pkg::DEPTH];
            b.last     = (i == n - 1);
            expected_beats.push_back(b);
          end
        end
      end
      dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
        if (fill_q >= dq_pkg::DEPTH) begin
          b.status = dq_pkg::STATUS_FULL;
        end else begin
          if (c == dq_pkg::CMD_PUSH_FRONT) begin
            head_q         = HEAD_W'((head_q + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH);
            ring_q[head_q] = v;
          end else begin
            ring_q[(head_q + fill_q) % dq_pkg::DEPTH] = v;
          end
          fill_q = fill_q + 1'b1;
        end
        expected_beats.push_back(b);
      end
      dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
        if (fill_q == 0) begin
          b.status = dq_pkg::STATUS_EMPTY;
        end else begin
          if (c == dq_pkg::CMD_POP_FRONT) head_q = HEAD_W'((head_q + 1) % dq_pkg::DEPTH);
          fill_q = fill_q - 1'b1;
        end
        expected_beats.push_back(b);
      end
      default: ;
    endcase
  endfunction

  task automatic add_row(input logic [2:0] c, input logic signed [31:0] v, input int reps,
                         input bit typed, input logic [1:0] st, input logic signed [31:0] d);
    stim_row_t r;
    r.cmd      = c;
    r.value    = v;
    r.reps     = reps;
    r.typed    = typed;
    r.t_status = st;
    r.t_data   = d;
    stim_rows.push_back(r);
  endtask

  // drive one command beat, wait for acceptance, then idle with start low if gap is nonzero
  task automatic send_cmd(input logic [2:0] c, input logic signed [31:0] v, input bit typed,
                          input logic [1:0] st, input logic signed [31:0] d, input int gap);
    int    base;
    beat_t b;
    start   <= 1'b1;
    cmd_i   <= c;
    value_i <= v;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    base = expected_beats.size();
    predict_cmd(c, v);
    if (typed) begin
      while (expected_beats.size() > base) void'(expected_beats.pop_back());
      b.status   = st;
      b.position = '0;
      b.data     = d;
      b.last     = 1'b1;
      expected_beats.push_back(b);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap(input bit allow);
    if (!allow || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int         push_pct;
    int         r;
    logic [2:0] c;

    add_row(dq_pkg::CMD_LIST,       '0,             1, 1, dq_pkg::STATUS_EMPTY, '0);
    add_row(dq_pkg::CMD_POP_FRONT,  '0,             1, 1, dq_pkg::STATUS_EMPTY, '0);
    add_row(dq_pkg::CMD_POP_BACK,   '0,             1, 1, dq_pkg::STATUS_EMPTY, '0);
    add_row(3'd5,                   32'sh1234_5678, 1, 0, dq_pkg::STATUS_OK,    '0);
    add_row(3'd7,                   -32'sd1,        1, 0, dq_pkg::STATUS_OK,    '0);
    add_row(dq_pkg::CMD_PUSH_BACK,  32'sh7fff_ffff, 1, 1, dq_pkg::STATUS_OK,    '0);
    add_row(dq_pkg::CMD_LIST,       '0,             1, 1, dq_pkg::STATUS_OK,
            32'sh7fff_ffff);
    add_row(dq_pkg::CMD_PUSH_FRONT, 32'sh8000_0000, 1, 1, dq_pkg::STATUS_OK,    '0);
    add_row(dq_pkg::CMD_PUSH_BACK,  '0,             1, 0, dq_pkg::STATUS_OK,    '0);
    add_row(dq_pkg::CMD_PUSH_FRONT, -32'sd1,        1, 0, dq_pkg::STATUS_OK,    '0);
    add_row(dq_pkg::CMD_PUSH_BACK,  32'sh5a5a_0000, 12, 0, dq_pkg::STATUS_OK,   '0);
    add_row(dq_pkg::CMD_PUSH_FRONT, 32'sh0bad_cafe, 1, 1, dq_pkg::STATUS_FULL,  '0);
    add_row(dq_pkg::CMD_PUSH_BACK,  32'sh0bad_cafe, 1, 1, dq_pkg::STATUS_FULL,  '0);
    add_row(dq_pkg::CMD_LIST,       '0,             1, 0, dq_pkg::STATUS_OK,    '0);
    add_row(dq_pkg::CMD_POP_BACK,   '0,             1, 0, dq_pkg::STATUS_OK,    '0);
    add_row(dq_pkg::CMD_POP_FRONT,  '0,             1, 0, dq_pkg::STATUS_OK,    '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      for (int k = 0; k < stim_rows[i].reps; k++) begin
        send_cmd(stim_rows[i].cmd, stim_rows[i].value + k, stim_rows[i].typed,
                 stim_rows[i].t_status, stim_rows[i].t_data, pick_gap(1'b1));
      end
    end

    push_pct = 41;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 62;
          1:       push_pct = 20;
          default: push_pct = 41;
        endcase
      end
      if (i == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 3)
        c = 3'($urandom_range(5, 7));
      else if (r < 18)
        c = dq_pkg::CMD_LIST;
      else if (r < 18 + push_pct)
        c = $urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK;
      else
        c = $urandom_range(0, 1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_BACK;
      send_cmd(c, pick_value(), 1'b0, dq_pkg::STATUS_OK, '0,
               pick_gap(i < RANDOM_ITEMS - QUIET_TAIL));
    end
    start <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_beats.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("unexpected beat: st=%0d pos=%0d data=%0d last=%0d",
                     status_o, position_o, data_o, last_o);
          errors++;
        end else begin
          want_beat = expected_beats.pop_front();
          if (status_o !== want_beat.status || position_o !== want_beat.position ||
              data_o !== want_beat.data || last_o !== want_beat.last) begin
            if (errors < REPORT_MAX)
              $display({"mismatch: exp st=%0d pos=%0d data=%0d last=%0d, ",
                        "got st=%0d pos=%0d data=%0d last=%0d"},
                       want_beat.status, want_beat.position, want_beat.data, want_beat.last,
                       status_o, position_o, data_o, last_o);
            errors++;
          end
        end
      end
      if ((start && !busy) || result_valid_o)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d beats outstanding", expected_beats.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
